// ===== rtl/edh_pkg.sv =====
// Shared constants, types and arithmetic helpers for the error diffusion halftone block.
`default_nettype none

package edh_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 4096;
  localparam int ERR_BITS  = 12;
  localparam int CNT_W     = $clog2(MAX_WIDTH);
  localparam int LANES     = 16;
  localparam int LANE_W    = $clog2(LANES);
  localparam int BANK_ROWS = MAX_WIDTH / (2 * LANES);
  localparam int ROW_W     = $clog2(BANK_ROWS);
  localparam int WORD_W    = LANES * ERR_BITS;

  // Datapath widths
  localparam int PIX_W   = 8;
  localparam int VAL_W   = ERR_BITS + 2;
  localparam int PROD_W  = ERR_BITS + 5;
  localparam int WIDTH_W = 13;

  // Register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic                 DIFFUSE_RESET    = 1'b1;
  localparam logic [WIDTH_W-1:0]   LINE_WIDTH_RESET = WIDTH_W'(640);
  localparam logic [PIX_W-1:0]     THRESHOLD_RESET  = PIX_W'(128);
  localparam logic [PIX_W-1:0]     PIX_FULL         = PIX_W'(255);

  localparam logic signed [VAL_W-1:0]  VAL_FULL = VAL_W'(255);
  localparam logic signed [PROD_W-1:0] ERR_HI   = PROD_W'((1 << (ERR_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] ERR_LO   = ~ERR_HI;
  localparam logic signed [PROD_W-1:0] DIV_RND  = PROD_W'(15);

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_DIFFUSE_ENABLE = 2'd0,
    REG_LINE_WIDTH     = 2'd1,
    REG_THRESHOLD      = 2'd2
  } reg_idx_t;

  typedef logic signed [ERR_BITS-1:0] err_t;

  // One line store write request
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] col;
    err_t             data;
  } lsw_t;

  // Clamp a wide error to the stored error range
  function automatic err_t sat_err(input logic signed [PROD_W-1:0] v);
    err_t r;
    if (v > ERR_HI) begin
      r = ERR_HI[ERR_BITS-1:0];
    end else if (v < ERR_LO) begin
      r = ERR_LO[ERR_BITS-1:0];
    end else begin
      r = v[ERR_BITS-1:0];
    end
    return r;
  endfunction

  // Divide by 16, truncating toward zero
  function automatic logic signed [PROD_W-1:0] div16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    if (p[PROD_W-1]) begin
      q = (p + DIV_RND) >>> 4;
    end else begin
      q = p >>> 4;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/error_diffusion_halftone.sv =====
// Floyd-Steinberg error diffusion halftoner with a banked line store and APB registers.
`default_nettype none

// Takes one 8-bit gray pixel per clock in raster order, unless stalled, and returns
// one pixel per transaction: 0 or 255 with diffusion on, the input pixel with it off.
// Each pixel is registered in the working stage, then in the output register; the
// block holds off input only when both its output register and its working
// stage are full. The next-row error store is two banks (even and odd columns) of
// 128 rows by 16 lanes of 12 bits, each bank with one read and one write per clock,
// so the pixel read, the write one column behind and the extra write at the end of
// a row never compete for a port. Frame start clears all 256 per-row valid bits
// together instead of sweeping the store, so no clearing pass or dead time follows
// reset or a new frame. Registers: diffuse_enable at 0x0, line_width at 0x4,
// threshold at 0x8; write them only while no pixel is in flight.
module error_diffusion_halftone (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [edh_pkg::PIX_W-1:0]   in_pixel_in,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [edh_pkg::PIX_W-1:0]   out_pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [edh_pkg::ADDR_W-1:0]  paddr,
  input  logic [edh_pkg::DATA_W-1:0]  pwdata,
  output logic [edh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import edh_pkg::*;

  // Configuration registers
  logic                diffuse_en_r;
  logic [WIDTH_W-1:0]  line_width_r;
  logic [PIX_W-1:0]    thresh_r;
  logic                cfg_wr;
  reg_idx_t            reg_sel;

  // Pipeline control
  logic in_acc;
  logic b_vld_r, b_vld_nxt;
  logic b_adv;
  logic out_vld_r;
  logic [PIX_W-1:0] out_pix_r;

  // Stage A
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [WIDTH_W-1:0] eff_w;
  logic [CNT_W-1:0]   x_a;
  logic [WIDTH_W-1:0] x_a1;
  logic               last_a;
  logic [ROW_W-1:0]   rd_row;
  logic [LANE_W-1:0]  rd_lane;
  logic               rd_vld;
  logic               fwd0, fwd1;

  // Stage B
  logic [PIX_W-1:0]  b_pix_r;
  logic              b_fs_r;
  logic [CNT_W-1:0]  b_x_r;
  logic              b_last_r;
  logic              b_bank_r;
  logic [LANE_W-1:0] b_lane_r;
  logic              b_rvld_r;
  logic              b_fwd_r;
  err_t              b_fwd_val_r;

  // Line store
  logic [WORD_W-1:0]    mem0 [BANK_ROWS];
  logic [WORD_W-1:0]    mem1 [BANK_ROWS];
  logic [WORD_W-1:0]    rdw0_r, rdw1_r;
  logic [BANK_ROWS-1:0] vld0_r, vld1_r;
  lsw_t                 wr0, wr1;
  logic [ROW_W-1:0]     wrow0, wrow1;
  logic [LANE_W-1:0]    wlane0, wlane1;
  logic [LANES-1:0]     we0, we1;
  logic [WORD_W-1:0]    wword0, wword1;

  // Error state
  err_t carry_r, bpl_r, bpc_r;

  // Arithmetic
  logic [WORD_W-1:0]          rd_word;
  err_t                       stored, carry_in, pl_in, pc_in;
  logic signed [VAL_W-1:0]    val, thr_s, err;
  logic                       below;
  logic [PIX_W-1:0]           halftone;
  logic signed [PROD_W-1:0]   errp, p7, p5, p3, t7, t5, t3, t1;
  err_t                       left_wr, newleft, new_carry, new_pc;

  //--------------------------------------------------------------------------
  // Register port
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diffuse_en_r <= DIFFUSE_RESET;
      line_width_r <= LINE_WIDTH_RESET;
      thresh_r     <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DIFFUSE_ENABLE: diffuse_en_r <= pwdata[0];
        REG_LINE_WIDTH:     line_width_r <= pwdata[WIDTH_W-1:0];
        REG_THRESHOLD:      thresh_r     <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DIFFUSE_ENABLE: prdata = DATA_W'(diffuse_en_r);
      REG_LINE_WIDTH:     prdata = DATA_W'(line_width_r);
      REG_THRESHOLD:      prdata = DATA_W'(thresh_r);
      default:            prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Handshake
  //--------------------------------------------------------------------------
  assign b_adv     = b_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall  = b_vld_r & ~b_adv;
  assign in_acc    = in_valid & ~in_stall;
  assign b_vld_nxt = in_acc | (b_vld_r & ~b_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
      if (b_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_pixel_out = out_pix_r;

  //--------------------------------------------------------------------------
  // Stage A: column tracking and line store read
  //--------------------------------------------------------------------------
  always_comb begin
    if (line_width_r == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (line_width_r > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = line_width_r;
    end
  end

  assign x_a     = in_frame_start ? '0 : col_r;
  assign x_a1    = WIDTH_W'(x_a) + WIDTH_W'(1);
  assign last_a  = (x_a1 >= eff_w);
  assign col_nxt = last_a ? '0 : x_a1[CNT_W-1:0];
  assign rd_row  = x_a[CNT_W-1:LANE_W+1];
  assign rd_lane = x_a[LANE_W:1];
  assign rd_vld  = x_a[0] ? vld1_r[rd_row] : vld0_r[rd_row];

  // Catch a write landing on the entry read at the same edge
  assign fwd0 = wr0.en && (wr0.col == x_a);
  assign fwd1 = wr1.en && (wr1.col == x_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
    end
  end

  // Capture the transaction into stage B
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix_r     <= in_pixel_in;
      b_fs_r      <= in_frame_start;
      b_x_r       <= x_a;
      b_last_r    <= last_a;
      b_bank_r    <= x_a[0];
      b_lane_r    <= rd_lane;
      b_rvld_r    <= rd_vld & ~in_frame_start;
      b_fwd_r     <= (fwd0 | fwd1) & ~in_frame_start;
      b_fwd_val_r <= fwd0 ? wr0.data : wr1.data;
    end
  end

  //--------------------------------------------------------------------------
  // Line store banks: even columns in bank 0, odd columns in bank 1
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdw0_r <= mem0[rd_row];
    end
    for (int l = 0; l < LANES; l++) begin
      if (we0[l]) begin
        mem0[wrow0][l*ERR_BITS +: ERR_BITS] <= wword0[l*ERR_BITS +: ERR_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdw1_r <= mem1[rd_row];
    end
    for (int l = 0; l < LANES; l++) begin
      if (we1[l]) begin
        mem1[wrow1][l*ERR_BITS +: ERR_BITS] <= wword1[l*ERR_BITS +: ERR_BITS];
      end
    end
  end

  // Row valid bits: frame start drops them all, a write marks its row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= '0;
      vld1_r <= '0;
    end else if (in_acc && in_frame_start) begin
      vld0_r <= '0;
      vld1_r <= '0;
    end else begin
      if (wr0.en) begin
        vld0_r[wrow0] <= 1'b1;
      end
      if (wr1.en) begin
        vld1_r[wrow1] <= 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stage B: threshold and error spread
  //--------------------------------------------------------------------------
  assign rd_word  = b_bank_r ? rdw1_r : rdw0_r;
  assign stored   = b_fwd_r  ? b_fwd_val_r :
                    b_rvld_r ? err_t'(rd_word[b_lane_r*ERR_BITS +: ERR_BITS]) : '0;
  assign carry_in = b_fs_r ? '0 : carry_r;
  assign pl_in    = b_fs_r ? '0 : bpl_r;
  assign pc_in    = b_fs_r ? '0 : bpc_r;

  always_comb begin
    val      = $signed({{(VAL_W-PIX_W){1'b0}}, b_pix_r}) + VAL_W'(stored) + VAL_W'(carry_in);
    thr_s    = $signed({{(VAL_W-PIX_W){1'b0}}, thresh_r});
    below    = (val < thr_s);
    halftone = below ? '0 : PIX_FULL;
    err      = below ? val : (val - VAL_FULL);
    errp     = PROD_W'(err);
    p7       = (errp <<< 3) - errp;
    p5       = (errp <<< 2) + errp;
    p3       = (errp <<< 1) + errp;
    t7       = div16(p7);
    t5       = div16(p5);
    t3       = div16(p3);
    t1       = div16(errp);
    left_wr  = sat_err(PROD_W'(pl_in) + t3);
    newleft  = sat_err(PROD_W'(pc_in) + t5);
    new_carry = sat_err(t7);
    new_pc    = sat_err(t1);
  end

  // Route the left write and the row-end write to their banks
  always_comb begin
    lsw_t left_req;
    lsw_t here_req;
    left_req.en   = b_adv & diffuse_en_r & (b_x_r != '0);
    left_req.col  = b_x_r - CNT_W'(1);
    left_req.data = left_wr;
    here_req.en   = b_adv & diffuse_en_r & b_last_r;
    here_req.col  = b_x_r;
    here_req.data = newleft;
    if (b_x_r[0]) begin
      wr0 = left_req;
      wr1 = here_req;
    end else begin
      wr0 = here_req;
      wr1 = left_req;
    end
  end

  // Build lane enables; a first write into a stale row rewrites the whole row
  always_comb begin
    wrow0  = wr0.col[CNT_W-1:LANE_W+1];
    wlane0 = wr0.col[LANE_W:1];
    wrow1  = wr1.col[CNT_W-1:LANE_W+1];
    wlane1 = wr1.col[LANE_W:1];
    for (int l = 0; l < LANES; l++) begin
      we0[l] = wr0.en & (~vld0_r[wrow0] | (LANE_W'(l) == wlane0));
      we1[l] = wr1.en & (~vld1_r[wrow1] | (LANE_W'(l) == wlane1));
      wword0[l*ERR_BITS +: ERR_BITS] = (LANE_W'(l) == wlane0) ? wr0.data : '0;
      wword1[l*ERR_BITS +: ERR_BITS] = (LANE_W'(l) == wlane1) ? wr1.data : '0;
    end
  end

  // Advance the error state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      bpl_r   <= '0;
      bpc_r   <= '0;
    end else if (b_adv) begin
      if (diffuse_en_r) begin
        carry_r <= b_last_r ? '0 : new_carry;
        bpl_r   <= b_last_r ? '0 : newleft;
        bpc_r   <= b_last_r ? '0 : new_pc;
      end else if (b_fs_r) begin
        carry_r <= '0;
        bpl_r   <= '0;
        bpc_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_pix_r <= diffuse_en_r ? halftone : b_pix_r;
    end
  end

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> b_vld_r)
    else $error("input held off with the working stage empty");

  a_frame_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_start) |=> (vld0_r == '0 && vld1_r == '0))
    else $error("frame start left line store rows marked valid");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_adv |=> out_vld_r)
    else $error("finished pixel did not reach the output register");

  a_write_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (wr0.en || wr1.en) |-> (diffuse_en_r && b_adv))
    else $error("line store written without diffusion or advance");

endmodule

`default_nettype wire

// ===== bench/halftone_checker.sv =====
// Checker for the halftone block: predicts every output pixel and compares it on arrival.
`timescale 1ns / 100ps

module halftone_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [edh_pkg::PIX_W-1:0]  in_pixel_in,
  input  logic                       in_frame_start,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [edh_pkg::PIX_W-1:0]  out_pixel_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edh_pkg::ADDR_W-1:0] paddr,
  input  logic [edh_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending
);
  import edh_pkg::*;

  localparam logic [PIX_W-1:0] BLACK = 8'd0;
  localparam logic [PIX_W-1:0] WHITE = 8'd255;

  // Shadow copies of the registers
  logic               diffuse_on;
  logic [WIDTH_W-1:0] row_len;
  logic [PIX_W-1:0]   level_cut;

  // Diffused error held for the next row, the next pixel and the two open columns
  err_t        below_err [MAX_WIDTH];
  err_t        carry_err;
  err_t        left_acc;
  err_t        center_acc;
  int unsigned column;

  // Predicted pixels not yet seen at the output
  logic [PIX_W-1:0] expected_pixels [$];

  // Clamp to the signed range of a stored error
  function automatic err_t clamp_error(input int v);
    int hi;
    hi = (1 << (ERR_BITS - 1)) - 1;
    if (v > hi) return err_t'(hi);
    if (v < -hi - 1) return err_t'(-hi - 1);
    return err_t'(v);
  endfunction

  function automatic void wipe_errors();
    foreach (below_err[i]) below_err[i] = '0;
    carry_err  = '0;
    left_acc   = '0;
    center_acc = '0;
    column     = 0;
  endfunction

  // Advance the error state by one pixel and return the halftone value
  function automatic logic [PIX_W-1:0] dither_pixel(input logic [PIX_W-1:0] pix,
                                                     input logic fs);
    int unsigned      span;
    int unsigned      x;
    logic             at_end;
    int               work;
    int               err;
    int               t7;
    int               t3;
    int               t5;
    int               t1;
    err_t             merged;
    logic [PIX_W-1:0] res;
    if (row_len == 0) span = 1;
    else if (row_len > MAX_WIDTH) span = MAX_WIDTH;
    else span = row_len;
    if (fs) wipe_errors();
    x = (column >= MAX_WIDTH) ? MAX_WIDTH - 1 : column;
    at_end = (x + 1 >= span);
    if (!diffuse_on) begin
      res = pix;
    end else begin
      work = int'(pix) + int'(below_err[x]) + int'(carry_err);
      res  = (work < int'(level_cut)) ? BLACK : WHITE;
      err  = work - int'(res);
      t7   = (err * 7) / 16;
      t3   = (err * 3) / 16;
      t5   = (err * 5) / 16;
      t1   = err / 16;
      // below-left lands one column behind; nothing left of column zero
      if (x > 0) below_err[x - 1] = clamp_error(int'(left_acc) + t3);
      merged = clamp_error(int'(center_acc) + t5);
      if (at_end) begin
        below_err[x] = merged;
        carry_err    = '0;
        left_acc     = '0;
        center_acc   = '0;
      end else begin
        carry_err  = clamp_error(t7);
        left_acc   = merged;
        center_acc = clamp_error(t1);
      end
    end
    column = at_end ? 0 : x + 1;
    return res;
  endfunction

  // Track register writes, check results, predict accepted pixels
  always @(posedge clk) begin : track
    logic [PIX_W-1:0] want;
    if (!rst_n) begin
      diffuse_on = 1'b1;
      row_len    = 13'd640;
      level_cut  = 8'd128;
      wipe_errors();
      expected_pixels.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_DIFFUSE_ENABLE: diffuse_on = pwdata[0];
          REG_LINE_WIDTH:     row_len    = pwdata[WIDTH_W-1:0];
          REG_THRESHOLD:      level_cut  = pwdata[PIX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: no transaction pending, actual %0d", out_pixel_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_out !== want) begin
            $error("pixel_out mismatch: expected %0d, actual %0d", want, out_pixel_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(dither_pixel(in_pixel_in, in_frame_start));
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

// ===== bench/tb_error_diffusion_halftone.sv =====
// Testbench top for the halftone block: drives pixels and registers and gives the verdict.
`timescale 1ns / 100ps

module tb_error_diffusion_halftone;
  import edh_pkg::*;

  localparam int STUCK_LIMIT  = 1000;
  localparam int PIXEL_BUDGET = 1900;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              in_frame_start;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  int   stuck_cycles = 0;
  int   rx_wait = 0;
  int   sent = 0;
  logic rx_took = 1'b0;
  bit   no_idle = 1'b0;

  always #4 clk = ~clk;

  error_diffusion_halftone DUT (.*);

  halftone_checker pixel_check (.*);

  function automatic int idle_draw();
    return no_idle ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Output side: hold stall for a drawn number of cycles after each transaction
  always @(posedge clk) rx_took <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (rx_took) rx_wait = idle_draw();
    else if (rx_wait > 0) rx_wait--;
    out_stall <= (rx_wait != 0);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic en, input logic [WIDTH_W-1:0] span,
                            input logic [PIX_W-1:0] thr);
    write_reg(REG_DIFFUSE_ENABLE, DATA_W'(en));
    write_reg(REG_LINE_WIDTH, DATA_W'(span));
    write_reg(REG_THRESHOLD, DATA_W'(thr));
  endtask

  // Send one pixel transaction after a drawn gap; returns at the accepting edge
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_in    <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every predicted pixel has come out
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic             en;
    logic             fs;
    logic [PIX_W-1:0] thr;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] base;
    int               span;
    int               count;
    int               phase;
    in_valid       = 1'b0;
    in_pixel_in    = '0;
    in_frame_start = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_n          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes and values around the threshold
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd127, 1'b0);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd170, 1'b0);
    push_pixel(8'd85, 1'b0);
    drain_pixels();

    // Short rows with the highest threshold
    set_config(1'b1, 13'd3, 8'd255);
    push_pixel(8'd254, 1'b1);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    drain_pixels();

    // One-pixel rows with threshold zero
    set_config(1'b1, 13'd1, 8'd0);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd1, 1'b0);
    drain_pixels();

    // Pass-through, zero width, frame start while disabled
    set_config(1'b0, 13'd0, 8'd128);
    push_pixel(8'd90, 1'b0);
    push_pixel(8'd165, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    drain_pixels();

    // Random phases: mostly short rows and gray fields with noise
    phase = 0;
    while (sent < PIXEL_BUDGET) begin
      en = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 7))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = PIX_W'($urandom_range(0, 255));
      endcase
      if (phase == 2) begin
        span = 4096;
      end else if (phase == 5) begin
        span = 8191;
      end else begin
        case ($urandom_range(0, 9))
          0:       span = 0;
          1:       span = 1;
          2:       span = $urandom_range(0, 8191);
          default: span = $urandom_range(2, 24);
        endcase
      end
      count   = (span > 64) ? $urandom_range(100, 400) : $urandom_range(20, 120);
      no_idle = ($urandom_range(0, 3) == 0);
      base    = PIX_W'($urandom_range(0, 255));
      set_config(en, WIDTH_W'(span), thr);
      for (int k = 0; k < count; k++) begin
        fs  = (k == 0) ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 63) == 0);
        pix = ($urandom_range(0, 1) != 0) ? PIX_W'($urandom_range(0, 255)) : base;
        push_pixel(pix, fs);
      end
      drain_pixels();
      phase++;
    end

    // Let any stray output show up before the verdict
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
